[hw/rtl/atr_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and character helpers for the address token recognizer.
// Used by every pipeline stage module and the top level; depends on nothing else.
package atr_pkg;

   // Window geometry and token rules.
   localparam int WinLen    = 10;
   localparam int DecDigits = WinLen - 1;
   localparam int MinDigits = 5;

   localparam logic [7:0] HEX_SUFFIX   = 8'h68;
   localparam logic [7:0] TRACE_PREFIX = 8'h23;

   // The decimal value is built from two groups of digits: a low group of five
   // digits and a high group of four, joined by one constant multiply.
   localparam int LoDigits = 5;
   localparam int HiDigits = DecDigits - LoDigits;
   localparam logic [31:0] DEC_SPLIT = 32'd100000;
   localparam logic [16:0] DEC_WEIGHT [LoDigits] = '{17'd1, 17'd10, 17'd100, 17'd1000,
                                                     17'd10000};

   typedef enum logic [1:0] {
      KIND_NONE  = 2'd0,
      KIND_HEX   = 2'd1,
      KIND_TRACE = 2'd2
   } token_kind_type;

   // Stage 1 result: classification and the digit values of every character.
   typedef struct packed {
      token_kind_type         kind;
      logic [3:0]             length;
      logic [3:0]             run;
      logic [WinLen-1:0][3:0] nib;
   } s1_type;

   // Stage 2 result: hex value extracted, decimal digits right aligned.
   typedef struct packed {
      token_kind_type            kind;
      logic [3:0]                length;
      logic [31:0]               hex_value;
      logic [DecDigits-1:0][3:0] digit;
   } s2_type;

   // Stage 3 result: decimal value as two partial sums.
   typedef struct packed {
      token_kind_type kind;
      logic [3:0]     length;
      logic [31:0]    hex_value;
      logic [16:0]    dec_lo;
      logic [13:0]    dec_hi;
   } s3_type;

   function automatic logic is_dec(input logic [7:0] c);
      is_dec = (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_hex(input logic [7:0] c);
      is_hex = is_dec(c) || ((c >= 8'h41) && (c <= 8'h46)) ||
               ((c >= 8'h61) && (c <= 8'h66));
   endfunction

   // Value of a hex digit; meaningless for other characters.
   function automatic logic [3:0] hex_nibble(input logic [7:0] c);
      logic [7:0] v;
      if (is_dec(c)) begin
         v = c - 8'h30;
      end else if (c <= 8'h46) begin
         v = c - 8'h37;
      end else begin
         v = c - 8'h57;
      end
      hex_nibble = v[3:0];
   endfunction

endpackage

[hw/rtl/atr_decode.sv]
`timescale 1ns / 1ps
// First pipeline stage: classifies each window character, finds the digit runs
// and decides the token kind and length. Depends on atr_pkg.
module atr_decode (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  logic [7:0]          chars [atr_pkg::WinLen],
   output logic                out_valid,
   input  logic                out_ready,
   output atr_pkg::s1_type     out_data
);

   logic            valid_ff, valid_in;
   atr_pkg::s1_type data_ff, data_in;

   // Find the hex run from the first character and the decimal run after it.
   always_comb begin
      logic [3:0] hex_run;
      logic [3:0] dec_run;
      logic       suffix;
      hex_run = 4'(atr_pkg::WinLen);
      for (int i = atr_pkg::WinLen - 1; i >= 0; i--) begin
         if (!atr_pkg::is_hex(chars[i])) begin
            hex_run = 4'(i);
         end
      end
      dec_run = 4'(atr_pkg::DecDigits);
      for (int i = atr_pkg::WinLen - 1; i >= 1; i--) begin
         if (!atr_pkg::is_dec(chars[i])) begin
            dec_run = 4'(i - 1);
         end
      end
      suffix = (hex_run < 4'(atr_pkg::WinLen)) &&
               (chars[hex_run] == atr_pkg::HEX_SUFFIX);

      for (int i = 0; i < atr_pkg::WinLen; i++) begin
         data_in.nib[i] = atr_pkg::hex_nibble(chars[i]);
      end
      if (suffix && (hex_run >= 4'(atr_pkg::MinDigits))) begin
         data_in.kind   = atr_pkg::KIND_HEX;
         data_in.length = hex_run + 4'd1;
         data_in.run    = hex_run;
      end else if ((chars[0] == atr_pkg::TRACE_PREFIX) &&
                   (dec_run >= 4'(atr_pkg::MinDigits))) begin
         data_in.kind   = atr_pkg::KIND_TRACE;
         data_in.length = dec_run + 4'd1;
         data_in.run    = dec_run;
      end else begin
         data_in.kind   = atr_pkg::KIND_NONE;
         data_in.length = 4'd0;
         data_in.run    = 4'd0;
      end
   end

   // The stage takes a new transaction when it is empty or its content moves on.
   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

[hw/rtl/atr_align.sv]
`timescale 1ns / 1ps
// Second pipeline stage: shifts the hex digits into a 32-bit value and right
// aligns the decimal digits of a trace token. Depends on atr_pkg.
module atr_align (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  atr_pkg::s1_type     in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output atr_pkg::s2_type     out_data
);

   logic            valid_ff, valid_in;
   atr_pkg::s2_type data_ff, data_in;

   always_comb begin
      logic [4*atr_pkg::WinLen-1:0] word;
      logic [4*atr_pkg::WinLen-1:0] shifted;
      logic [5:0]                   shamt;
      logic [3:0]                   idx;
      // Hex digits sit first character most significant; drop the unused tail.
      for (int i = 0; i < atr_pkg::WinLen; i++) begin
         word[4*(atr_pkg::WinLen-1-i) +: 4] = in_data.nib[i];
      end
      shamt   = {(4'(atr_pkg::WinLen) - in_data.run), 2'b00};
      shifted = word >> shamt;

      // Digit k of the trace counts 10^k; the last digit read is char[run].
      for (int k = 0; k < atr_pkg::DecDigits; k++) begin
         idx = in_data.run - 4'(k);
         if (4'(k) < in_data.run) begin
            data_in.digit[k] = in_data.nib[idx];
         end else begin
            data_in.digit[k] = 4'd0;
         end
      end
      data_in.kind      = in_data.kind;
      data_in.length    = in_data.length;
      data_in.hex_value = shifted[31:0];
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

[hw/rtl/atr_dec_sum.sv]
`timescale 1ns / 1ps
// Third pipeline stage: weights the aligned decimal digits and sums them in a
// low and a high group. Depends on atr_pkg.
module atr_dec_sum (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_ready,
   input  atr_pkg::s2_type     in_data,
   output logic                out_valid,
   input  logic                out_ready,
   output atr_pkg::s3_type     out_data
);

   logic            valid_ff, valid_in;
   atr_pkg::s3_type data_ff, data_in;

   // Each group stays below its power of ten, so the sums cannot overflow.
   always_comb begin
      logic [16:0] lo;
      logic [16:0] hi;
      lo = 17'd0;
      hi = 17'd0;
      for (int k = 0; k < atr_pkg::LoDigits; k++) begin
         lo = lo + 17'(in_data.digit[k] * atr_pkg::DEC_WEIGHT[k]);
      end
      for (int k = 0; k < atr_pkg::HiDigits; k++) begin
         hi = hi + 17'(in_data.digit[atr_pkg::LoDigits + k] * atr_pkg::DEC_WEIGHT[k]);
      end
      data_in.kind      = in_data.kind;
      data_in.length    = in_data.length;
      data_in.hex_value = in_data.hex_value;
      data_in.dec_lo    = lo;
      data_in.dec_hi    = hi[13:0];
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

[hw/rtl/atr_result.sv]
`timescale 1ns / 1ps
// Last pipeline stage: joins the decimal groups, selects the value by token kind
// and holds the result transaction for the consumer. Depends on atr_pkg.
module atr_result (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   output logic                    in_ready,
   input  atr_pkg::s3_type         in_data,
   output logic                    out_valid,
   input  logic                    out_ready,
   output atr_pkg::token_kind_type kind,
   output logic [31:0]             value,
   output logic [3:0]              length
);

   logic                    valid_ff, valid_in;
   atr_pkg::token_kind_type kind_ff;
   logic [31:0]             value_ff, value_in;
   logic [3:0]              length_ff;

   // High group times 10^5 plus low group; at most nine digits, so it fits.
   always_comb begin
      logic [31:0] dec_value;
      dec_value = 32'(in_data.dec_hi) * atr_pkg::DEC_SPLIT + 32'(in_data.dec_lo);
      case (in_data.kind)
         atr_pkg::KIND_HEX:   value_in = in_data.hex_value;
         atr_pkg::KIND_TRACE: value_in = dec_value;
         default:             value_in = 32'd0;
      endcase
   end

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (in_ready && in_valid) begin
         kind_ff   <= in_data.kind;
         value_ff  <= value_in;
         length_ff <= in_data.length;
      end
   end

   assign out_valid = valid_ff;
   assign kind      = kind_ff;
   assign value     = value_ff;
   assign length    = length_ff;

endmodule

[hw/rtl/address_token_recognizer.sv]
`timescale 1ns / 1ps
// Address token recognizer top level: four register stages in a chain.
// Depends on atr_pkg, atr_decode, atr_align, atr_dec_sum and atr_result.
//
// The block looks at a ten-character window that starts at the scan position and
// reports a hex address token (5 to 9 hex digits followed by 'h', value kept to
// 32 bits) or a trace token ('#' followed by 5 to 9 decimal digits), with its
// kind, value and length in characters including the 'h' or '#'. Every window
// produces exactly one result transaction, with kind, value and length all zero
// when no token starts there. The datapath is four register stages (decode,
// align, decimal group sums, join and select); a request passes through the
// decode, align, sum and result registers in order, and one request is accepted
// every cycle as long as the consumer keeps rsp_ready high. Each stage holds its
// transaction while the stage after it is full and stalled, and req_ready follows
// rsp_ready combinationally through the stages.
module address_token_recognizer (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_0,
   input  logic [7:0]  req_char_1,
   input  logic [7:0]  req_char_2,
   input  logic [7:0]  req_char_3,
   input  logic [7:0]  req_char_4,
   input  logic [7:0]  req_char_5,
   input  logic [7:0]  req_char_6,
   input  logic [7:0]  req_char_7,
   input  logic [7:0]  req_char_8,
   input  logic [7:0]  req_char_9,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_token_kind,
   output logic [31:0] rsp_token_value,
   output logic [3:0]  rsp_token_length
);

   logic [7:0]              chars [atr_pkg::WinLen];
   logic                    s1_valid, s1_ready;
   logic                    s2_valid, s2_ready;
   logic                    s3_valid, s3_ready;
   atr_pkg::s1_type         s1_data;
   atr_pkg::s2_type         s2_data;
   atr_pkg::s3_type         s3_data;
   atr_pkg::token_kind_type kind;

   // Gather the window characters.
   assign chars[0] = req_char_0;
   assign chars[1] = req_char_1;
   assign chars[2] = req_char_2;
   assign chars[3] = req_char_3;
   assign chars[4] = req_char_4;
   assign chars[5] = req_char_5;
   assign chars[6] = req_char_6;
   assign chars[7] = req_char_7;
   assign chars[8] = req_char_8;
   assign chars[9] = req_char_9;

   atr_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .chars     (chars),
      .out_valid (s1_valid),
      .out_ready (s1_ready),
      .out_data  (s1_data)
   );

   atr_align u_align (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .in_data   (s1_data),
      .out_valid (s2_valid),
      .out_ready (s2_ready),
      .out_data  (s2_data)
   );

   atr_dec_sum u_dec_sum (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s2_valid),
      .in_ready  (s2_ready),
      .in_data   (s2_data),
      .out_valid (s3_valid),
      .out_ready (s3_ready),
      .out_data  (s3_data)
   );

   atr_result u_result (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s3_valid),
      .in_ready  (s3_ready),
      .in_data   (s3_data),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .kind      (kind),
      .value     (rsp_token_value),
      .length    (rsp_token_length)
   );

   assign rsp_token_kind = kind;

   // A window without a token reports zero value and zero length.
   a_none_is_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (kind == atr_pkg::KIND_NONE) |->
         (rsp_token_value == 32'd0) && (rsp_token_length == 4'd0))
      else $error("no-token result carries nonzero value or length");

   // Any token spans six to ten characters.
   a_token_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (kind != atr_pkg::KIND_NONE) |->
         (rsp_token_length >= 4'd6) && (rsp_token_length <= 4'd10))
      else $error("token length out of range");

   // A trace value has at most nine decimal digits.
   a_trace_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (kind == atr_pkg::KIND_TRACE) |->
         (rsp_token_value < 32'd1000000000))
      else $error("trace value exceeds nine decimal digits");

   // With the consumer always ready, the pipeline accepts every cycle.
   a_full_rate: assert property (@(posedge clock) disable iff (reset)
      rsp_ready && $past(rsp_ready) && $past(rsp_ready, 2) && $past(rsp_ready, 3) |->
         req_ready)
      else $error("pipeline stalls although the consumer is ready");

endmodule

[tb/tb_address_token_recognizer.sv]
`timescale 1ns / 1ps
// Self-checking testbench for address_token_recognizer: directed and random windows,
// an in-bench token predictor, random idling on both channels and output back-pressure.
// Depends on atr_pkg and the address_token_recognizer RTL.
module tb_address_token_recognizer;

   localparam int HOLD_CYCLES    = 80;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 8;

   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_F = 8'h46;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_F = 8'h66;
   localparam logic [7:0] CH_HIGH    = 8'h80;

   typedef logic [atr_pkg::WinLen-1:0][7:0] window_type;

   typedef struct packed {
      atr_pkg::token_kind_type kind;
      logic [31:0]             value;
      logic [3:0]              length;
   } token_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_char_0 = 8'h00;
   logic [7:0]  req_char_1 = 8'h00;
   logic [7:0]  req_char_2 = 8'h00;
   logic [7:0]  req_char_3 = 8'h00;
   logic [7:0]  req_char_4 = 8'h00;
   logic [7:0]  req_char_5 = 8'h00;
   logic [7:0]  req_char_6 = 8'h00;
   logic [7:0]  req_char_7 = 8'h00;
   logic [7:0]  req_char_8 = 8'h00;
   logic [7:0]  req_char_9 = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [1:0]  rsp_token_kind;
   logic [31:0] rsp_token_value;
   logic [3:0]  rsp_token_length;

   token_result_type expected_tokens[$];
   int error_count   = 0;
   int send_idle_pct = 36;
   int rsp_idle_pct  = 36;
   int hold_requests = 0;
   int hold_served   = 0;
   int hold_left     = 0;
   int quiet_cycles  = 0;

   address_token_recognizer u_top (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_char_0       (req_char_0),
      .req_char_1       (req_char_1),
      .req_char_2       (req_char_2),
      .req_char_3       (req_char_3),
      .req_char_4       (req_char_4),
      .req_char_5       (req_char_5),
      .req_char_6       (req_char_6),
      .req_char_7       (req_char_7),
      .req_char_8       (req_char_8),
      .req_char_9       (req_char_9),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_token_value  (rsp_token_value),
      .rsp_token_length (rsp_token_length)
   );

   always #10 clock = ~clock;

   // Token predictor: the hex form is tried first, then the '#' trace form.
   function automatic token_result_type predict_token(input window_type w);
      token_result_type r;
      logic [31:0]      acc;
      logic [3:0]       nib;
      logic             stop;
      logic             ended;
      logic             ok;
      int               n;
      r.kind   = atr_pkg::KIND_NONE;
      r.value  = '0;
      r.length = '0;
      acc   = '0;
      n     = 0;
      stop  = 1'b0;
      ended = 1'b0;
      for (int i = 0; i < atr_pkg::WinLen; i++) begin
         if (!stop) begin
            if (w[i] == atr_pkg::HEX_SUFFIX) begin
               ended = (n != 0);
               stop  = 1'b1;
            end else begin
               ok  = 1'b1;
               nib = '0;
               if (w[i] >= CH_ZERO && w[i] <= CH_NINE) begin
                  nib = 4'(w[i] - CH_ZERO);
               end else if (w[i] >= CH_UPPER_A && w[i] <= CH_UPPER_F) begin
                  nib = 4'(w[i] - CH_UPPER_A + 8'd10);
               end else if (w[i] >= CH_LOWER_A && w[i] <= CH_LOWER_F) begin
                  nib = 4'(w[i] - CH_LOWER_A + 8'd10);
               end else begin
                  ok = 1'b0;
               end
               if (ok) begin
                  // Shifting out the top keeps only the low 32 bits of a nine-digit value.
                  acc = {acc[27:0], nib};
                  n++;
               end else begin
                  stop = 1'b1;
               end
            end
         end
      end
      if (ended && n >= atr_pkg::MinDigits) begin
         r.kind   = atr_pkg::KIND_HEX;
         r.value  = acc;
         r.length = 4'(n + 1);
      end else if (w[0] == atr_pkg::TRACE_PREFIX) begin
         acc  = '0;
         n    = 0;
         stop = 1'b0;
         for (int i = 1; i < atr_pkg::WinLen; i++) begin
            if (!stop) begin
               if (w[i] >= CH_ZERO && w[i] <= CH_NINE) begin
                  acc = acc * 32'd10 + 32'(w[i] - CH_ZERO);
                  n++;
               end else begin
                  stop = 1'b1;
               end
            end
         end
         if (n >= atr_pkg::MinDigits) begin
            r.kind   = atr_pkg::KIND_TRACE;
            r.value  = acc;
            r.length = 4'(n + 1);
         end
      end
      return r;
   endfunction

   // Characters past the end of the text arrive as zero.
   function automatic window_type text_window(input string text);
      window_type w;
      w = '0;
      for (int i = 0; i < atr_pkg::WinLen && i < text.len(); i++) begin
         w[i] = text[i];
      end
      return w;
   endfunction

   function automatic logic [7:0] dec_char();
      return CH_ZERO + 8'($urandom_range(9));
   endfunction

   function automatic logic [7:0] hex_char();
      logic [7:0] c;
      case ($urandom_range(2))
         0: c = dec_char();
         1: c = CH_UPPER_A + 8'($urandom_range(5));
         default: c = CH_LOWER_A + 8'($urandom_range(5));
      endcase
      return c;
   endfunction

   // Bytes weighted toward the characters the recognizer cares about.
   function automatic logic [7:0] mixed_char();
      logic [7:0] c;
      case ($urandom_range(7))
         0: c = 8'h00;
         1: c = atr_pkg::HEX_SUFFIX;
         2: c = atr_pkg::TRACE_PREFIX;
         3: c = dec_char();
         4: c = hex_char();
         5: c = CH_HIGH | hex_char();
         default: c = 8'($urandom_range(255));
      endcase
      return c;
   endfunction

   function automatic window_type mixed_window();
      window_type w;
      for (int i = 0; i < atr_pkg::WinLen; i++) begin
         w[i] = mixed_char();
      end
      return w;
   endfunction

   // Sometimes the text ends right after the token.
   function automatic window_type cut_after(input window_type w, input int last);
      window_type r;
      r = w;
      if ($urandom_range(3) == 0) begin
         for (int i = last + 1; i < atr_pkg::WinLen; i++) begin
            r[i] = 8'h00;
         end
      end
      return r;
   endfunction

   function automatic window_type hex_window(input int digits, input logic suffix);
      window_type w;
      w = mixed_window();
      for (int i = 0; i < digits; i++) begin
         w[i] = hex_char();
      end
      if (digits < atr_pkg::WinLen) begin
         if (suffix) begin
            w[digits] = atr_pkg::HEX_SUFFIX;
         end else begin
            while (w[digits] == atr_pkg::HEX_SUFFIX) begin
               w[digits] = mixed_char();
            end
         end
      end
      return cut_after(w, digits);
   endfunction

   function automatic window_type trace_window(input int digits);
      window_type w;
      w    = mixed_window();
      w[0] = atr_pkg::TRACE_PREFIX;
      for (int i = 1; i <= digits; i++) begin
         w[i] = dec_char();
      end
      return cut_after(w, digits);
   endfunction

   // Sends one window, waiting for the handshake, and records what it should produce.
   task automatic send_window(input window_type w);
      logic taken;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_char_0 <= w[0];
      req_char_1 <= w[1];
      req_char_2 <= w[2];
      req_char_3 <= w[3];
      req_char_4 <= w[4];
      req_char_5 <= w[5];
      req_char_6 <= w[6];
      req_char_7 <= w[7];
      req_char_8 <= w[8];
      req_char_9 <= w[9];
      taken = 1'b0;
      while (!taken) begin
         @(negedge clock);
         taken = req_ready;
         @(posedge clock);
      end
      expected_tokens.insert(expected_tokens.size(), predict_token(w));
   endtask

   task automatic send_text(input string text);
      send_window(text_window(text));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (expected_tokens.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic test_hex_tokens();
      send_text("12345h");
      send_text("00000h");
      send_text("1234567h");
      send_text("ABCDEFabch");
      send_text("fffffffffh");
      send_text("89abCDEFh0");
      wait_drained();
   endtask

   task automatic test_trace_tokens();
      send_text("#00000");
      send_text("#12345");
      send_text("#999999999");
      send_text("#1234567890");
      send_text("#123456x");
      wait_drained();
   endtask

   task automatic test_rejected_windows();
      window_type w;
      send_text("1234h");
      send_text("h12345h");
      send_text("0123456789");
      send_text("12345g");
      send_text("#1234");
      send_text("#h12345");
      send_text("");
      send_window('1);
      // Digit, 'h' and '#' with the high bit set are not those characters.
      w = text_window("12345h");
      w[5] = atr_pkg::HEX_SUFFIX | CH_HIGH;
      send_window(w);
      w = text_window("#12345");
      w[0] = atr_pkg::TRACE_PREFIX | CH_HIGH;
      send_window(w);
      w = text_window("12345h");
      w[2] = CH_ZERO | CH_HIGH;
      send_window(w);
      wait_drained();
   endtask

   // Mostly well-formed tokens with random content, the rest broken forms and noise.
   task automatic send_random_windows(input int count);
      window_type w;
      int         pick;
      for (int k = 0; k < count; k++) begin
         pick = $urandom_range(99);
         if (pick < 38) begin
            w = hex_window($urandom_range(9, atr_pkg::MinDigits), 1'b1);
         end else if (pick < 68) begin
            w = trace_window($urandom_range(9, atr_pkg::MinDigits));
         end else if (pick < 75) begin
            w = hex_window($urandom_range(atr_pkg::MinDigits - 1, 0), 1'b1);
         end else if (pick < 81) begin
            w = hex_window($urandom_range(atr_pkg::WinLen, atr_pkg::MinDigits), 1'b0);
         end else if (pick < 86) begin
            w = trace_window($urandom_range(atr_pkg::MinDigits - 1, 0));
         end else begin
            w = mixed_window();
         end
         send_window(w);
      end
   endtask

   task automatic test_random_windows();
      send_idle_pct = 36;
      rsp_idle_pct  = 36;
      send_random_windows(400);
      wait_drained();
   endtask

   task automatic test_full_rate();
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      send_random_windows(150);
      wait_drained();
   endtask

   task automatic test_output_backpressure();
      send_idle_pct = 0;
      rsp_idle_pct  = 36;
      hold_requests++;
      send_random_windows(50);
      wait_drained();
   endtask

   // Result receiver: random stalls, plus long hold-offs on request.
   always @(posedge clock) begin
      if (hold_served != hold_requests) begin
         hold_served <= hold_requests;
         hold_left   <= HOLD_CYCLES;
         rsp_ready   <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   // Result checker; sampled mid-cycle, where all signals are settled.
   always @(negedge clock) begin
      token_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_tokens.size() == 0) begin
            $error("unexpected result transaction: kind %0d value %0h length %0d",
                   rsp_token_kind, rsp_token_value, rsp_token_length);
            error_count++;
         end else begin
            want = expected_tokens.pop_front();
            if (rsp_token_kind !== want.kind) begin
               $error("token_kind: expected %0d, actual %0d", want.kind, rsp_token_kind);
               error_count++;
            end
            if (rsp_token_value !== want.value) begin
               $error("token_value: expected %0h, actual %0h", want.value, rsp_token_value);
               error_count++;
            end
            if (rsp_token_length !== want.length) begin
               $error("token_length: expected %0d, actual %0d", want.length,
                      rsp_token_length);
               error_count++;
            end
         end
      end
   end

   // Watchdog on cycles with no transaction on either channel.
   always @(negedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_hex_tokens();
      test_trace_tokens();
      test_rejected_windows();
      test_random_windows();
      test_full_rate();
      test_output_backpressure();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0 && expected_tokens.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
